// ===== design/vram_first_fit_evicting_allocator_assert.svh =====
// Assertion macros shared by the allocator RTL.
// Stand-alone header; the including module supplies clk and rst.
`ifndef VRAM_FIRST_FIT_EVICTING_ALLOCATOR_ASSERT_SVH
`define VRAM_FIRST_FIT_EVICTING_ALLOCATOR_ASSERT_SVH
`ifndef SYNTH
`define VFFA_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define VFFA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define VFFA_ASSERT_IMPL(lbl, ante, cons, msg)
`define VFFA_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== design/vffa_pkg.sv =====
// Shared types and codes of the texture memory allocator.
// No dependencies; used by vffa_ctrl, vffa_dp and the top level.
package vffa_pkg;

  localparam int ADDR_W   = 23;
  localparam int ID_W     = 8;
  localparam int CLUT_W   = 11;
  localparam int CMD_W    = 3;
  localparam int STATUS_W = 2;
  localparam int NEED_W   = 24;
  localparam int PADDR_W  = 3;
  localparam int PDATA_W  = 32;

  localparam logic [CMD_W-1:0] CMD_INIT       = 3'd0;
  localparam logic [CMD_W-1:0] CMD_BIND       = 3'd1;
  localparam logic [CMD_W-1:0] CMD_FREE       = 3'd2;
  localparam logic [CMD_W-1:0] CMD_NEXT_FRAME = 3'd3;
  localparam logic [CMD_W-1:0] CMD_INVALIDATE = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
  localparam logic [STATUS_W-1:0] ST_TOO_LARGE  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_TABLE_FULL = 2'd2;

  localparam logic CFG_IDX_VRAM_BASE = 1'b0;

  typedef enum logic [4:0] {
    S_IDLE, S_DISPATCH, S_SC_RD, S_SC_CHK, S_SC_END, S_HIT, S_SPLIT, S_SI_RD, S_SI_WR,
    S_ALLOC, S_BIND, S_RB_RD, S_RB_CHK, S_RF_LD, S_RF_RD, S_RF_CHK, S_RF_DONE,
    S_SR_RD, S_SR_WR, S_EV_RD, S_EV_CHK, S_EV_REL, S_LW_RD, S_LW_CHK, S_LW_END,
    S_NF_RD, S_NF_CHK, S_EMIT
  } state_t;

  typedef enum logic [5:0] {
    OP_NONE, OP_LATCH, OP_INIT, OP_RD_K, OP_SCAN, OP_SET_ST1, OP_USE_FIT, OP_EV_START,
    OP_REL_START, OP_INVAL, OP_INS_START, OP_SET_ST2, OP_RD_KM1, OP_WR_K_DEC, OP_WR_NEW,
    OP_ALLOC, OP_BIND, OP_RD_RM1, OP_R_DEC, OP_RD_R, OP_LOAD_CUR, OP_RD_R1, OP_MERGE,
    OP_RD_K1, OP_CNT_DEC, OP_WR_K_INC, OP_WR_R, OP_K_R1, OP_EV_TAKE, OP_K_INC,
    OP_LW_START, OP_LW_ACC, OP_W_STEP, OP_NF_UPD, OP_EMIT
  } dp_op_t;

  typedef struct packed {
    logic k_lt_cnt;
    logic k1_lt_cnt;
    logic r_gt0;
    logic r1_lt_cnt;
    logic k_gt_idx1;
    logic rd_used;
    logic rd_hit;
    logic rd_evict;
    logic fit_ok;
    logic have_fit;
    logic total_short;
    logic any_used;
    logic split_need;
    logic table_full;
    logic out_free;
    logic [CMD_W-1:0] cmd;
  } dp_status_t;

endpackage

// ===== design/vram_first_fit_evicting_allocator.sv =====
// Top level of the first-fit texture memory allocator with eviction.
// Depends on vffa_pkg, vffa_ctrl and vffa_dp; holds the configuration register.
//
//   channel | direction | handshake            | beat contents
//   --------+-----------+----------------------+---------------------------------------
//   cfg     | in/out    | psel/penable, pready | paddr, pwrite, pwdata, prdata (vram_base)
//   in      | in        | in_valid/in_ready    | cmd, tex_id, tex_size, has_clut, clut_size
//   out     | out       | out_valid/out_ready  | tex_address, clut_address, send_*, status
//
// One command at a time; every beat on in yields exactly one beat on out.
// The table is a single-port-per-cycle memory with a registered read, so each
// segment visited takes a read state and then a check or write state; scans, split
// shifts, releases, eviction passes and threshold steps all walk it that way.
// Reset is synchronous and needs no clearing pass; in_ready returns high once
// the result sits in the output register; a stalled out holds that beat, and the next result waits for it.
module vram_first_fit_evicting_allocator #(
  parameter int MAX_SEGMENTS = 64,
  parameter int VRAM_BYTES   = 4194304,
  parameter int COUNT_BITS   = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [vffa_pkg::PADDR_W-1:0]      paddr,
  input  logic [vffa_pkg::PDATA_W-1:0]      pwdata,
  output logic [vffa_pkg::PDATA_W-1:0]      prdata,
  output logic                              pready,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [vffa_pkg::CMD_W-1:0]        cmd,
  input  logic [vffa_pkg::ID_W-1:0]         tex_id,
  input  logic [vffa_pkg::ADDR_W-1:0]       tex_size,
  input  logic                              has_clut,
  input  logic [vffa_pkg::CLUT_W-1:0]       clut_size,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [vffa_pkg::ADDR_W-1:0]       tex_address,
  output logic [vffa_pkg::ADDR_W-1:0]       clut_address,
  output logic                              send_texture,
  output logic                              send_clut,
  output logic [vffa_pkg::STATUS_W-1:0]     status
);

  logic [vffa_pkg::ADDR_W-1:0] vram_base;
  logic                        reg_sel;
  vffa_pkg::dp_status_t        st;
  vffa_pkg::dp_op_t            op;

  // word index: register 0 at byte 0, anything above reads zero and drops writes
  assign reg_sel = paddr[2] == vffa_pkg::CFG_IDX_VRAM_BASE;
  assign pready = 1'b1;
  assign prdata = reg_sel ? vffa_pkg::PDATA_W'(vram_base) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      vram_base <= '0;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      vram_base <= pwdata[vffa_pkg::ADDR_W-1:0];
    end
  end

  vffa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .op       (op)
  );

  vffa_dp #(
    .MAX_SEGMENTS (MAX_SEGMENTS),
    .VRAM_BYTES   (VRAM_BYTES),
    .COUNT_BITS   (COUNT_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .op           (op),
    .st           (st),
    .vram_base    (vram_base),
    .cmd          (cmd),
    .tex_id       (tex_id),
    .tex_size     (tex_size),
    .has_clut     (has_clut),
    .clut_size    (clut_size),
    .out_ready    (out_ready),
    .out_valid    (out_valid),
    .tex_address  (tex_address),
    .clut_address (clut_address),
    .send_texture (send_texture),
    .send_clut    (send_clut),
    .status       (status)
  );

endmodule

// ===== design/vffa_ctrl.sv =====
// Sequencer of the allocator: walks scans, shifts, releases and eviction passes.
// Depends on vffa_pkg; drives vffa_dp through one operation code per cycle.
module vffa_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  vffa_pkg::dp_status_t st,
  output vffa_pkg::dp_op_t    op
);

  vffa_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= vffa_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    op = vffa_pkg::OP_NONE;
    in_ready = 1'b0;
    case (state)
      vffa_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          op = vffa_pkg::OP_LATCH;
          state_next = vffa_pkg::S_DISPATCH;
        end
      end
      vffa_pkg::S_DISPATCH: begin
        if (st.cmd == vffa_pkg::CMD_INIT) begin
          op = vffa_pkg::OP_INIT;
          state_next = vffa_pkg::S_EMIT;
        end else if (st.cmd == vffa_pkg::CMD_BIND || st.cmd == vffa_pkg::CMD_FREE ||
                     st.cmd == vffa_pkg::CMD_INVALIDATE) begin
          state_next = vffa_pkg::S_SC_RD;
        end else if (st.cmd == vffa_pkg::CMD_NEXT_FRAME) begin
          state_next = vffa_pkg::S_NF_RD;
        end else begin
          state_next = vffa_pkg::S_EMIT;
        end
      end
      vffa_pkg::S_SC_RD: begin
        if (st.k_lt_cnt) begin
          op = vffa_pkg::OP_RD_K;
          state_next = vffa_pkg::S_SC_CHK;
        end else begin
          state_next = vffa_pkg::S_SC_END;
        end
      end
      vffa_pkg::S_SC_CHK: begin
        op = vffa_pkg::OP_SCAN;
        state_next = st.rd_hit ? vffa_pkg::S_HIT : vffa_pkg::S_SC_RD;
      end
      vffa_pkg::S_SC_END: begin
        if (st.cmd != vffa_pkg::CMD_BIND) begin
          state_next = vffa_pkg::S_EMIT;
        end else if (st.total_short) begin
          op = vffa_pkg::OP_SET_ST1;
          state_next = vffa_pkg::S_EMIT;
        end else if (st.have_fit) begin
          op = vffa_pkg::OP_USE_FIT;
          state_next = vffa_pkg::S_SPLIT;
        end else begin
          op = vffa_pkg::OP_EV_START;
          state_next = vffa_pkg::S_EV_RD;
        end
      end
      vffa_pkg::S_HIT: begin
        if (st.cmd == vffa_pkg::CMD_BIND) begin
          op = vffa_pkg::OP_BIND;
          state_next = vffa_pkg::S_EMIT;
        end else if (st.cmd == vffa_pkg::CMD_FREE) begin
          op = vffa_pkg::OP_REL_START;
          state_next = vffa_pkg::S_RB_RD;
        end else if (st.cmd == vffa_pkg::CMD_INVALIDATE) begin
          op = vffa_pkg::OP_INVAL;
          state_next = vffa_pkg::S_EMIT;
        end else begin
          state_next = vffa_pkg::S_EMIT;
        end
      end
      vffa_pkg::S_SPLIT: begin
        if (st.split_need && !st.table_full) begin
          op = vffa_pkg::OP_INS_START;
          state_next = vffa_pkg::S_SI_RD;
        end else if (st.split_need) begin
          op = vffa_pkg::OP_SET_ST2;
          state_next = vffa_pkg::S_ALLOC;
        end else begin
          state_next = vffa_pkg::S_ALLOC;
        end
      end
      vffa_pkg::S_SI_RD: begin
        if (st.k_gt_idx1) begin
          op = vffa_pkg::OP_RD_KM1;
          state_next = vffa_pkg::S_SI_WR;
        end else begin
          op = vffa_pkg::OP_WR_NEW;
          state_next = vffa_pkg::S_ALLOC;
        end
      end
      vffa_pkg::S_SI_WR: begin
        op = vffa_pkg::OP_WR_K_DEC;
        state_next = vffa_pkg::S_SI_RD;
      end
      vffa_pkg::S_ALLOC: begin
        op = vffa_pkg::OP_ALLOC;
        state_next = vffa_pkg::S_BIND;
      end
      vffa_pkg::S_BIND: begin
        op = vffa_pkg::OP_BIND;
        state_next = vffa_pkg::S_EMIT;
      end
      vffa_pkg::S_RB_RD: begin
        if (st.r_gt0) begin
          op = vffa_pkg::OP_RD_RM1;
          state_next = vffa_pkg::S_RB_CHK;
        end else begin
          op = vffa_pkg::OP_RD_R;
          state_next = vffa_pkg::S_RF_LD;
        end
      end
      vffa_pkg::S_RB_CHK: begin
        if (!st.rd_used) begin
          op = vffa_pkg::OP_R_DEC;
          state_next = vffa_pkg::S_RB_RD;
        end else begin
          op = vffa_pkg::OP_RD_R;
          state_next = vffa_pkg::S_RF_LD;
        end
      end
      vffa_pkg::S_RF_LD: begin
        op = vffa_pkg::OP_LOAD_CUR;
        state_next = vffa_pkg::S_RF_RD;
      end
      vffa_pkg::S_RF_RD: begin
        if (st.r1_lt_cnt) begin
          op = vffa_pkg::OP_RD_R1;
          state_next = vffa_pkg::S_RF_CHK;
        end else begin
          op = vffa_pkg::OP_WR_R;
          state_next = vffa_pkg::S_RF_DONE;
        end
      end
      vffa_pkg::S_RF_CHK: begin
        if (!st.rd_used) begin
          op = vffa_pkg::OP_MERGE;
          state_next = vffa_pkg::S_SR_RD;
        end else begin
          op = vffa_pkg::OP_WR_R;
          state_next = vffa_pkg::S_RF_DONE;
        end
      end
      vffa_pkg::S_RF_DONE: begin
        if (st.cmd != vffa_pkg::CMD_BIND) begin
          state_next = vffa_pkg::S_EMIT;
        end else if (st.fit_ok) begin
          state_next = vffa_pkg::S_SPLIT;
        end else begin
          op = vffa_pkg::OP_K_R1;
          state_next = vffa_pkg::S_EV_RD;
        end
      end
      vffa_pkg::S_SR_RD: begin
        if (st.k1_lt_cnt) begin
          op = vffa_pkg::OP_RD_K1;
          state_next = vffa_pkg::S_SR_WR;
        end else begin
          op = vffa_pkg::OP_CNT_DEC;
          state_next = vffa_pkg::S_RF_RD;
        end
      end
      vffa_pkg::S_SR_WR: begin
        op = vffa_pkg::OP_WR_K_INC;
        state_next = vffa_pkg::S_SR_RD;
      end
      vffa_pkg::S_EV_RD: begin
        if (st.k_lt_cnt) begin
          op = vffa_pkg::OP_RD_K;
          state_next = vffa_pkg::S_EV_CHK;
        end else begin
          op = vffa_pkg::OP_LW_START;
          state_next = vffa_pkg::S_LW_RD;
        end
      end
      vffa_pkg::S_EV_CHK: begin
        if (st.rd_evict) begin
          op = vffa_pkg::OP_EV_TAKE;
          state_next = vffa_pkg::S_EV_REL;
        end else begin
          op = vffa_pkg::OP_K_INC;
          state_next = vffa_pkg::S_EV_RD;
        end
      end
      vffa_pkg::S_EV_REL: begin
        op = vffa_pkg::OP_REL_START;
        state_next = vffa_pkg::S_RB_RD;
      end
      vffa_pkg::S_LW_RD: begin
        if (st.k_lt_cnt) begin
          op = vffa_pkg::OP_RD_K;
          state_next = vffa_pkg::S_LW_CHK;
        end else begin
          state_next = vffa_pkg::S_LW_END;
        end
      end
      vffa_pkg::S_LW_CHK: begin
        op = vffa_pkg::OP_LW_ACC;
        state_next = vffa_pkg::S_LW_RD;
      end
      vffa_pkg::S_LW_END: begin
        if (!st.any_used) begin
          op = vffa_pkg::OP_SET_ST1;
          state_next = vffa_pkg::S_EMIT;
        end else begin
          op = vffa_pkg::OP_W_STEP;
          state_next = vffa_pkg::S_EV_RD;
        end
      end
      vffa_pkg::S_NF_RD: begin
        if (st.k_lt_cnt) begin
          op = vffa_pkg::OP_RD_K;
          state_next = vffa_pkg::S_NF_CHK;
        end else begin
          state_next = vffa_pkg::S_EMIT;
        end
      end
      vffa_pkg::S_NF_CHK: begin
        op = vffa_pkg::OP_NF_UPD;
        state_next = vffa_pkg::S_NF_RD;
      end
      vffa_pkg::S_EMIT: begin
        if (st.out_free) begin
          op = vffa_pkg::OP_EMIT;
          state_next = vffa_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = vffa_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// ===== design/vffa_dp.sv =====
// Datapath of the allocator: segment table memory, index counters, working entry
// and result register. Depends on vffa_pkg and the assertion macro header.
`include "vram_first_fit_evicting_allocator_assert.svh"
module vffa_dp #(
  parameter int MAX_SEGMENTS = 64,
  parameter int VRAM_BYTES   = 4194304,
  parameter int COUNT_BITS   = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  vffa_pkg::dp_op_t                  op,
  output vffa_pkg::dp_status_t              st,
  input  logic [vffa_pkg::ADDR_W-1:0]       vram_base,
  input  logic [vffa_pkg::CMD_W-1:0]        cmd,
  input  logic [vffa_pkg::ID_W-1:0]         tex_id,
  input  logic [vffa_pkg::ADDR_W-1:0]       tex_size,
  input  logic                              has_clut,
  input  logic [vffa_pkg::CLUT_W-1:0]       clut_size,
  input  logic                              out_ready,
  output logic                              out_valid,
  output logic [vffa_pkg::ADDR_W-1:0]       tex_address,
  output logic [vffa_pkg::ADDR_W-1:0]       clut_address,
  output logic                              send_texture,
  output logic                              send_clut,
  output logic [vffa_pkg::STATUS_W-1:0]     status
);

  localparam int IW = $clog2(MAX_SEGMENTS);
  localparam int CW = $clog2(MAX_SEGMENTS + 1);
  localparam int LW = $clog2(VRAM_BYTES + 1);
  localparam int SW = (LW > vffa_pkg::NEED_W) ? LW : vffa_pkg::NEED_W;
  localparam int CB = COUNT_BITS;
  localparam int WW = CB + 1;
  localparam int TW = CB + 2;
  localparam logic [LW-1:0] VRAM_L = LW'(VRAM_BYTES);
  localparam logic [CW-1:0] MAX_C  = CW'(MAX_SEGMENTS);

  typedef struct packed {
    logic [LW-1:0]               start;
    logic [LW-1:0]               len;
    logic [vffa_pkg::ID_W-1:0]   owner;
    logic                        used;
    logic [CB-1:0]               this_f;
    logic [CB-1:0]               last_f;
    logic                        img;
    logic                        tbl;
  } entry_t;

  function automatic logic [WW-1:0] weight_of(input logic [CB-1:0] t, input logic [CB-1:0] l);
    logic [WW-1:0] res;
    if (t == l) res = WW'(l);
    else if (t < l) res = WW'(l) + WW'(l - t);
    else res = WW'(t) + WW'(1);
    return res;
  endfunction

  entry_t mem [MAX_SEGMENTS];
  entry_t rd_q, rdata, rst_entry, wd, cur, fit, bind_ent;
  logic   rd_fresh_q, fresh;
  logic   we, re;
  logic [IW-1:0] wa, ra;

  logic [vffa_pkg::CMD_W-1:0]    cmd_q;
  logic [vffa_pkg::ID_W-1:0]     id_q;
  logic [vffa_pkg::ADDR_W-1:0]   tsize_q;
  logic                          clut_q;
  logic [vffa_pkg::NEED_W-1:0]   need_q, need_in;
  logic [CW-1:0]                 k, count;
  logic [IW-1:0]                 r, idx, fit_idx;
  logic                          have_fit, any_used;
  logic [SW-1:0]                 total;
  logic [TW-1:0]                 w;
  logic [WW-1:0]                 lowest, rd_weight;
  logic [LW-1:0]                 base_c;
  logic [vffa_pkg::ADDR_W-1:0]   res_tex, res_clut;
  logic                          res_stex, res_sclut;
  logic [vffa_pkg::STATUS_W-1:0] res_status;

  assign need_in = vffa_pkg::NEED_W'(tex_size) +
                   (has_clut ? vffa_pkg::NEED_W'(clut_size) : '0);
  assign base_c = (SW'(vram_base) > SW'(VRAM_L)) ? VRAM_L : LW'(vram_base);

  always_comb begin
    rst_entry = '0;
    rst_entry.len = VRAM_L;
  end

  assign rdata = rd_fresh_q ? rst_entry : rd_q;
  assign rd_weight = weight_of(rdata.this_f, rdata.last_f);

  // bind: mark loaded and count the use, saturating
  always_comb begin
    bind_ent = cur;
    bind_ent.img = 1'b1;
    bind_ent.tbl = cur.tbl | clut_q;
    if (cur.this_f != {CB{1'b1}}) bind_ent.this_f = cur.this_f + CB'(1);
  end

  // status toward the sequencer
  always_comb begin
    st.k_lt_cnt    = k < count;
    st.k1_lt_cnt   = ({1'b0, k} + (CW+1)'(1)) < {1'b0, count};
    st.r_gt0       = r != '0;
    st.r1_lt_cnt   = (CW'(r) + CW'(1)) < count;
    st.k_gt_idx1   = k > (CW'(idx) + CW'(1));
    st.rd_used     = rdata.used;
    st.rd_hit      = rdata.used && (rdata.owner == id_q);
    st.rd_evict    = rdata.used && (TW'(rd_weight) <= w);
    st.fit_ok      = SW'(cur.len) >= SW'(need_q);
    st.have_fit    = have_fit;
    st.total_short = SW'(need_q) > total;
    st.any_used    = any_used;
    st.split_need  = SW'(cur.len) > SW'(need_q);
    st.table_full  = count >= MAX_C;
    st.out_free    = !out_valid || out_ready;
    st.cmd         = cmd_q;
  end

  // memory port selection
  always_comb begin
    we = 1'b0;
    wa = '0;
    wd = cur;
    re = 1'b0;
    ra = '0;
    case (op)
      vffa_pkg::OP_INIT: begin
        we = 1'b1;
        wd = '0;
        wd.start = base_c;
        wd.len = VRAM_L - base_c;
      end
      vffa_pkg::OP_REL_START: begin
        we = 1'b1;
        wa = idx;
        wd = '0;
        wd.start = cur.start;
        wd.len = cur.len;
      end
      vffa_pkg::OP_INVAL: begin
        we = 1'b1;
        wa = idx;
        wd.img = 1'b0;
        wd.tbl = 1'b0;
      end
      vffa_pkg::OP_WR_K_DEC, vffa_pkg::OP_WR_K_INC: begin
        we = 1'b1;
        wa = k[IW-1:0];
        wd = rdata;
      end
      vffa_pkg::OP_WR_NEW: begin
        we = 1'b1;
        wa = idx + IW'(1);
        wd = '0;
        wd.start = cur.start + LW'(need_q);
        wd.len = cur.len - LW'(need_q);
      end
      vffa_pkg::OP_BIND: begin
        we = 1'b1;
        wa = idx;
        wd = bind_ent;
      end
      vffa_pkg::OP_WR_R: begin
        we = 1'b1;
        wa = r;
      end
      vffa_pkg::OP_NF_UPD: begin
        we = rdata.used;
        wa = k[IW-1:0];
        wd = rdata;
        wd.last_f = rdata.this_f;
        wd.this_f = '0;
      end
      vffa_pkg::OP_RD_K: begin
        re = 1'b1;
        ra = k[IW-1:0];
      end
      vffa_pkg::OP_RD_KM1: begin
        re = 1'b1;
        ra = k[IW-1:0] - IW'(1);
      end
      vffa_pkg::OP_RD_K1: begin
        re = 1'b1;
        ra = k[IW-1:0] + IW'(1);
      end
      vffa_pkg::OP_RD_RM1: begin
        re = 1'b1;
        ra = r - IW'(1);
      end
      vffa_pkg::OP_RD_R: begin
        re = 1'b1;
        ra = r;
      end
      vffa_pkg::OP_RD_R1: begin
        re = 1'b1;
        ra = r + IW'(1);
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    if (re) begin
      rd_q <= mem[ra];
      rd_fresh_q <= fresh && (ra == '0);
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      fresh <= 1'b1;
      count <= CW'(1);
      k <= '0;
      out_valid <= 1'b0;
    end else begin
      if (we && wa == '0) fresh <= 1'b0;
      if (op == vffa_pkg::OP_EMIT) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      case (op)
        vffa_pkg::OP_LATCH, vffa_pkg::OP_EV_START, vffa_pkg::OP_LW_START,
        vffa_pkg::OP_W_STEP: k <= '0;
        vffa_pkg::OP_INIT: count <= CW'(1);
        vffa_pkg::OP_SCAN: if (!st.rd_hit) k <= k + CW'(1);
        vffa_pkg::OP_K_INC, vffa_pkg::OP_LW_ACC, vffa_pkg::OP_NF_UPD,
        vffa_pkg::OP_WR_K_INC: k <= k + CW'(1);
        vffa_pkg::OP_INS_START: k <= count;
        vffa_pkg::OP_WR_K_DEC: k <= k - CW'(1);
        vffa_pkg::OP_WR_NEW: count <= count + CW'(1);
        vffa_pkg::OP_CNT_DEC: count <= count - CW'(1);
        vffa_pkg::OP_MERGE, vffa_pkg::OP_K_R1: k <= CW'(r) + CW'(1);
        default: begin
          k <= k;
        end
      endcase
    end
  end

  // payload and working registers
  always_ff @(posedge clk) begin
    case (op)
      vffa_pkg::OP_LATCH: begin
        cmd_q <= cmd;
        id_q <= tex_id;
        tsize_q <= tex_size;
        clut_q <= has_clut;
        need_q <= need_in;
        total <= '0;
        have_fit <= 1'b0;
        res_tex <= '0;
        res_clut <= '0;
        res_stex <= 1'b0;
        res_sclut <= 1'b0;
        res_status <= vffa_pkg::ST_OK;
      end
      vffa_pkg::OP_SCAN: begin
        if (st.rd_hit) begin
          cur <= rdata;
          idx <= k[IW-1:0];
        end else begin
          total <= total + SW'(rdata.len);
          if (!have_fit && !rdata.used && SW'(rdata.len) >= SW'(need_q)) begin
            have_fit <= 1'b1;
            fit <= rdata;
            fit_idx <= k[IW-1:0];
          end
        end
      end
      vffa_pkg::OP_SET_ST1: res_status <= vffa_pkg::ST_TOO_LARGE;
      vffa_pkg::OP_SET_ST2: res_status <= vffa_pkg::ST_TABLE_FULL;
      vffa_pkg::OP_USE_FIT: begin
        cur <= fit;
        idx <= fit_idx;
      end
      vffa_pkg::OP_EV_START: w <= '0;
      vffa_pkg::OP_REL_START: r <= idx;
      vffa_pkg::OP_WR_NEW: cur.len <= LW'(need_q);
      vffa_pkg::OP_ALLOC: begin
        cur.used <= 1'b1;
        cur.owner <= id_q;
        cur.this_f <= '0;
        cur.last_f <= CB'(1);
        cur.img <= 1'b0;
        cur.tbl <= 1'b0;
      end
      vffa_pkg::OP_BIND: begin
        res_tex <= vffa_pkg::ADDR_W'(SW'(cur.start));
        res_clut <= vffa_pkg::ADDR_W'(SW'(cur.start) + SW'(tsize_q));
        res_stex <= !cur.img;
        res_sclut <= clut_q && !cur.tbl;
      end
      vffa_pkg::OP_R_DEC: r <= r - IW'(1);
      vffa_pkg::OP_LOAD_CUR: cur <= rdata;
      vffa_pkg::OP_MERGE: cur.len <= cur.len + rdata.len;
      vffa_pkg::OP_WR_R: idx <= r;
      vffa_pkg::OP_EV_TAKE: begin
        cur <= rdata;
        idx <= k[IW-1:0];
      end
      vffa_pkg::OP_LW_START: any_used <= 1'b0;
      vffa_pkg::OP_LW_ACC: begin
        if (rdata.used) begin
          if (!any_used || rd_weight < lowest) lowest <= rd_weight;
          any_used <= 1'b1;
        end
      end
      vffa_pkg::OP_W_STEP: w <= (TW'(lowest) > w) ? TW'(lowest) : w + TW'(1);
      vffa_pkg::OP_EMIT: begin
        tex_address <= res_tex;
        clut_address <= res_clut;
        send_texture <= res_stex;
        send_clut <= res_sclut;
        status <= res_status;
      end
      default: begin
        cur <= cur;
      end
    endcase
  end

  `VFFA_ASSERT_IMPL(a_count_range, 1'b1, (count != '0) && (count <= MAX_C), "segment count out of range")
  `VFFA_ASSERT_IMPL(a_index_bound, 1'b1, k <= count, "scan index beyond segment count")
  `VFFA_ASSERT_IMPL(a_port_clash, we, !re, "table read and write in one cycle")

endmodule
